[rtl/core/id3u_pkg.sv]
// Shared types and constants for the ID3 text to UTF-8 transcoder.
// Used by the front end, the character queue and the byte serializer.
// No dependencies.
package id3u_pkg;

    localparam int CAP_W       = 13;
    localparam int CP_W        = 21;
    localparam int LEN_W       = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One character to serialize; len 0 is an empty end-of-frame marker.
    typedef struct packed {
        logic [CP_W-1:0]  cp;
        logic [LEN_W-1:0] len;
        logic             frame_end;
    } char_entry_t;

    typedef struct packed {
        logic push_valid;
        logic push_ready;
    } push_ctrl_t;

endpackage

[rtl/core/id3u_front.sv]
// Front end: decodes the encoding selector, builds UTF-16 code units and
// surrogate pairs, applies the capacity limit and queues whole characters.
// Depends on id3u_pkg.
module id3u_front
    import id3u_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [CAP_W-1:0] text_capacity,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // payload_byte
    input  logic             s_tlast,   // frame_last
    output push_ctrl_t       push_ctrl,
    input  logic             push_ready,
    output char_entry_t      push_entry
);

    typedef enum logic [2:0] {
        PH_SELECT = 3'b001,
        PH_RUN    = 3'b010,
        PH_IDLE   = 3'b100
    } phase_t;

    localparam logic [1:0] MODE_LATIN1  = 2'd0;
    localparam logic [1:0] MODE_UTF16   = 2'd1;
    localparam logic [1:0] MODE_UTF16BE = 2'd2;
    localparam logic [1:0] MODE_UTF8    = 2'd3;

    function automatic logic [LEN_W-1:0] cp_len(input logic [CP_W-1:0] cp);
        logic [LEN_W-1:0] n;
        if (cp <= 21'h00007f) begin
            n = 3'd1;
        end else if (cp <= 21'h0007ff) begin
            n = 3'd2;
        end else if (cp <= 21'h00ffff) begin
            n = 3'd3;
        end else begin
            n = 3'd4;
        end
        return n;
    endfunction

    phase_t           phase_reg, phase_next;
    logic [1:0]       mode_reg, mode_next;
    logic             msb_first_reg, msb_first_next;
    logic             first_pend_reg, first_pend_next;
    logic [7:0]       half_byte_reg, half_byte_next;
    logic             half_valid_reg, half_valid_next;
    logic [9:0]       held_reg, held_next;
    logic             held_valid_reg, held_valid_next;
    logic [CAP_W-1:0] count_reg, count_next;
    logic             pend_valid_reg, pend_valid_next;
    char_entry_t      pend_entry_reg, pend_entry_next;

    logic             s_fire;
    logic [15:0]      unit;
    logic             unit_low, unit_high;
    logic             va, vb, raw_a;
    logic [CP_W-1:0]  cpa, cpb;
    logic [LEN_W-1:0] lena, lenb;
    logic [CAP_W:0]   sum_a, sum_b;
    logic [CAP_W-1:0] cnt_mid;
    logic             fit_a, fit_b;
    char_entry_t      ent_a, ent_b, ent_null;

    assign s_tready  = !pend_valid_reg && push_ready;
    assign s_fire    = s_tvalid && s_tready;
    assign unit      = msb_first_reg ? {half_byte_reg, s_tdata} : {s_tdata, half_byte_reg};
    assign unit_low  = (unit >= 16'hdc00) && (unit <= 16'hdfff);
    assign unit_high = (unit >= 16'hd800) && (unit <= 16'hdbff);

    always_comb begin
        phase_next      = phase_reg;
        mode_next       = mode_reg;
        msb_first_next  = msb_first_reg;
        first_pend_next = first_pend_reg;
        half_byte_next  = half_byte_reg;
        half_valid_next = half_valid_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        va    = 1'b0;
        vb    = 1'b0;
        raw_a = 1'b0;
        cpa   = '0;
        cpb   = '0;

        unique case (phase_reg)
            PH_SELECT: begin
                if (s_tdata <= 8'd3) begin
                    mode_next       = s_tdata[1:0];
                    phase_next      = PH_RUN;
                    first_pend_next = (s_tdata[1:0] == MODE_UTF16);
                end else begin
                    phase_next = PH_IDLE;
                end
            end
            PH_RUN: begin
                case (mode_reg) inside
                    MODE_LATIN1, MODE_UTF8: begin
                        if (s_tdata == 8'd0) begin
                            phase_next = PH_IDLE;
                        end else begin
                            va    = 1'b1;
                            raw_a = (mode_reg == MODE_UTF8);
                            cpa   = {{(CP_W-8){1'b0}}, s_tdata};
                        end
                    end
                    MODE_UTF16, MODE_UTF16BE: begin
                        if (!half_valid_reg) begin
                            half_byte_next  = s_tdata;
                            half_valid_next = 1'b1;
                        end else begin
                            half_valid_next = 1'b0;
                            first_pend_next = 1'b0;
                            if (first_pend_reg && unit == 16'hfffe) begin
                                msb_first_next = 1'b0;
                            end else if (first_pend_reg && unit == 16'hfeff) begin
                                msb_first_next = msb_first_reg;
                            end else begin
                                if (held_valid_reg) begin
                                    held_valid_next = 1'b0;
                                    va = 1'b1;
                                    if (unit_low) begin
                                        cpa = 21'h010000 + {1'b0, held_reg, unit[9:0]};
                                    end else begin
                                        cpa = {5'd0, 6'b110110, held_reg};
                                    end
                                end
                                if (!(held_valid_reg && unit_low)) begin
                                    if (unit == 16'h0000) begin
                                        phase_next = PH_IDLE;
                                    end else if (unit_high) begin
                                        held_next       = unit[9:0];
                                        held_valid_next = 1'b1;
                                    end else begin
                                        vb  = 1'b1;
                                        cpb = {5'd0, unit};
                                    end
                                end
                            end
                        end
                    end
                endcase
            end
            PH_IDLE: begin
                phase_next = PH_IDLE;
            end
            default: begin
                phase_next = PH_SELECT;
            end
        endcase

        if (s_tlast && phase_next == PH_RUN && held_valid_next) begin
            vb  = 1'b1;
            cpb = {5'd0, 6'b110110, held_next};
        end

        lena    = raw_a ? 3'd1 : cp_len(cpa);
        lenb    = cp_len(cpb);
        sum_a   = {1'b0, count_reg} + {{(CAP_W+1-LEN_W){1'b0}}, lena};
        fit_a   = va && (sum_a < {1'b0, text_capacity});
        cnt_mid = fit_a ? sum_a[CAP_W-1:0] : count_reg;
        sum_b   = {1'b0, cnt_mid} + {{(CAP_W+1-LEN_W){1'b0}}, lenb};
        fit_b   = vb && (sum_b < {1'b0, text_capacity});
        count_next = fit_b ? sum_b[CAP_W-1:0] : cnt_mid;

        if (s_tlast) begin
            phase_next      = PH_SELECT;
            mode_next       = MODE_LATIN1;
            msb_first_next  = 1'b1;
            first_pend_next = 1'b0;
            half_byte_next  = 8'd0;
            half_valid_next = 1'b0;
            held_next       = 10'd0;
            held_valid_next = 1'b0;
            count_next      = '0;
        end

        ent_a    = '{cp: cpa, len: lena, frame_end: s_tlast && !fit_b};
        ent_b    = '{cp: cpb, len: lenb, frame_end: s_tlast};
        ent_null = '{cp: '0, len: '0, frame_end: 1'b1};

        if (pend_valid_reg) begin
            push_entry = pend_entry_reg;
        end else if (fit_a) begin
            push_entry = ent_a;
        end else if (fit_b) begin
            push_entry = ent_b;
        end else begin
            push_entry = ent_null;
        end
        push_ctrl.push_valid = pend_valid_reg || (s_fire && (fit_a || fit_b || s_tlast));
        push_ctrl.push_ready = push_ready;

        pend_valid_next = pend_valid_reg && !push_ready;
        pend_entry_next = pend_entry_reg;
        if (s_fire) begin
            pend_valid_next = fit_a && fit_b;
            pend_entry_next = ent_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_SELECT;
            mode_reg       <= MODE_LATIN1;
            msb_first_reg  <= 1'b1;
            first_pend_reg <= 1'b0;
            half_valid_reg <= 1'b0;
            held_valid_reg <= 1'b0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                phase_reg      <= phase_next;
                mode_reg       <= mode_next;
                msb_first_reg  <= msb_first_next;
                first_pend_reg <= first_pend_next;
                half_valid_reg <= half_valid_next;
                held_valid_reg <= held_valid_next;
                count_reg      <= count_next;
            end
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            half_byte_reg <= half_byte_next;
            held_reg      <= held_next;
        end
        pend_entry_reg <= pend_entry_next;
    end

endmodule

[rtl/core/id3u_queue.sv]
// Short character queue between the front end and the byte serializer.
// Depends on id3u_pkg.
module id3u_queue
    import id3u_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  push_ctrl_t  push_ctrl,
    output logic        push_ready,
    input  char_entry_t push_entry,
    output logic        head_valid,
    output char_entry_t head_entry,
    input  logic        pop
);

    char_entry_t       slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];
    assign do_push    = push_ctrl.push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

[rtl/core/id3u_back.sv]
// Byte serializer, depends on id3u_pkg: turns queued characters into UTF-8
// bytes, one per cycle unless stalled, behind a registered output stage.
module id3u_back
    import id3u_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        head_valid,
    input  char_entry_t head_entry,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // text_byte
    output logic        m_tuser,   // text_valid
    output logic        m_tlast    // text_end
);

    function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp,
                                             input logic [LEN_W-1:0] len,
                                             input logic [1:0] idx);
        logic [7:0] b;
        b = 8'd0;
        case (len)
            3'd1: b = cp[7:0];
            3'd2: b = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
            3'd3: begin
                case (idx)
                    2'd0:    b = {4'b1110, cp[15:12]};
                    2'd1:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            3'd4: begin
                case (idx)
                    2'd0:    b = {5'b11110, cp[20:18]};
                    2'd1:    b = {2'b10, cp[17:12]};
                    2'd2:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            default: b = 8'd0;
        endcase
        return b;
    endfunction

    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_flag_reg, out_flag_next;
    logic       out_end_reg, out_end_next;
    logic       advance, last_byte;

    assign advance   = head_valid && (!out_valid_reg || m_tready);
    assign last_byte = (head_entry.len == '0) || ({1'b0, idx_reg} == head_entry.len - 3'd1);
    assign pop       = advance && last_byte;

    always_comb begin
        idx_next       = idx_reg;
        out_byte_next  = out_byte_reg;
        out_flag_next  = out_flag_reg;
        out_end_next   = out_end_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (advance) begin
            idx_next       = last_byte ? 2'd0 : idx_reg + 2'd1;
            out_valid_next = 1'b1;
            out_byte_next  = utf8_byte(head_entry.cp, head_entry.len, idx_reg);
            out_flag_next  = (head_entry.len != '0);
            out_end_next   = head_entry.frame_end && last_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_byte_reg <= out_byte_next;
        out_flag_reg <= out_flag_next;
        out_end_reg  <= out_end_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_flag_reg;
    assign m_tlast  = out_end_reg;

endmodule

[rtl/core/id3_text_to_utf8_transcoder.sv]
// Top level of the ID3 text frame to UTF-8 transcoder.
// Depends on id3u_pkg, id3u_front, id3u_queue and id3u_back.
//
// The block takes one frame byte per cycle while s_tready is high and emits
// UTF-8 bytes one per cycle while m_tready is high, at least one byte per
// character. An input byte that completes two characters holds the input
// until the second character enters the four-entry queue. Every frame_last
// byte yields at least one result, with tlast set on its final one. The
// capacity register resets to 256 and should be written only while no frame
// is in flight.
module id3_text_to_utf8_transcoder
    import id3u_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata,  // text_capacity
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,    // payload_byte
    input  logic             s_tlast,    // frame_last
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,    // text_byte
    output logic             m_tuser,    // text_valid
    output logic             m_tlast     // text_end
);

    logic [CAP_W-1:0] capacity_reg;
    push_ctrl_t       push_ctrl;
    logic             push_ready;
    char_entry_t      push_entry;
    logic             head_valid;
    char_entry_t      head_entry;
    logic             pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_W'(256);
        end else if (cfg_we) begin
            capacity_reg <= cfg_wdata;
        end
    end

    id3u_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .text_capacity (capacity_reg),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .push_ctrl     (push_ctrl),
        .push_ready    (push_ready),
        .push_entry    (push_entry)
    );

    id3u_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_ctrl  (push_ctrl),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop)
    );

    id3u_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule
